[sv/til_pkg.sv]
// Shared types and constants for the trie insert and lookup unit.
package til_pkg;

    localparam int LETTER_W = 8;
    localparam int STATUS_W = 2;
    localparam int NODES_W  = 11;

    localparam logic [LETTER_W-1:0] FIRST_LETTER = 8'd97;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

    typedef struct packed {
        logic                cmd;
        logic [LETTER_W-1:0] letter;
        logic                no_char;
        logic                last;
    } item_t;

    typedef struct packed {
        logic                word_found;
        logic                prefix_found;
        logic [STATUS_W-1:0] status;
        logic [NODES_W-1:0]  nodes_used;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ZERO,
        ST_LREAD,
        ST_LEVAL
    } state_t;

    typedef struct packed {
        logic accept;
        logic eval;
        logic zero;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_go;
        logic in_last;
        logic item_last;
        logic alloc;
        logic out_free;
    } ctrl_stat_t;

endpackage

[sv/trie_insert_lookup_unit.sv]
// Top level of the trie insert and lookup unit.
//
//  channel  | signals                             | carries
//  ---------+-------------------------------------+-------------------------------
//  item     | item_valid, item_ready, item        | one letter (or none) of a word
//  result   | result_valid, result_ready, result  | one transaction per last item
//
// A letter is accepted, then the child row read from the node table is evaluated.
// A letter that allocates a node also passes through ST_ZERO, which writes the new row to zero.
// A last item then reads the end mark of the cursor node (ST_LREAD), then finishes (ST_LEVAL).
// No clearing pass: the root row reads as empty until first written.
// A finished result waits in the output register; the next item is accepted meanwhile,
// and finish holds only while the output register is still occupied.
module trie_insert_lookup_unit #(
    parameter int MAX_NODES = 1024,
    parameter int ALPHABET  = 26
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  til_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output til_pkg::result_t result
);
    import til_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    til_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    til_datapath #(
        .MAX_NODES (MAX_NODES),
        .ALPHABET  (ALPHABET)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (stat.in_go || stat.in_last) |=> !item_ready)
        else $error("item_ready high right after an accepted transaction");

    a_found_needs_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.word_found || result.prefix_found))
        else $error("word_found without prefix_found");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == STAT_OK || result.status == STAT_FULL
                          || result.status == STAT_BAD))
        else $error("undefined status code");

    a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.eval, cmd.zero, cmd.finish}))
        else $error("more than one datapath command in a cycle");

endmodule

[sv/til_ctrl.sv]
// Sequencer for letter walk, node allocation and word finish.
module til_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  til_pkg::ctrl_stat_t stat,
    output til_pkg::ctrl_cmd_t  cmd
);
    import til_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (stat.in_go)
                        state_next = ST_EVAL;
                    else if (stat.in_last)
                        state_next = ST_LREAD;
                end
            end
            ST_EVAL:
            begin
                if (stat.alloc)
                    state_next = ST_ZERO;
                else if (stat.item_last)
                    state_next = ST_LREAD;
                else
                    state_next = ST_IDLE;
            end
            ST_ZERO:
            begin
                state_next = stat.item_last ? ST_LREAD : ST_IDLE;
            end
            ST_LREAD:
            begin
                state_next = ST_LEVAL;
            end
            ST_LEVAL:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.accept = item_valid;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            ST_ZERO:
            begin
                cmd.zero = 1'b1;
            end
            ST_LEVAL:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[sv/til_datapath.sv]
// Node table memory, word cursor, node counter and result register.
module til_datapath #(
    parameter int MAX_NODES = 1024,
    parameter int ALPHABET  = 26
) (
    input  logic                clk,
    input  logic                rst_n,
    input  til_pkg::item_t      item,
    input  til_pkg::ctrl_cmd_t  cmd,
    output til_pkg::ctrl_stat_t stat,
    output logic                result_valid,
    input  logic                result_ready,
    output til_pkg::result_t    result
);
    import til_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int IDX_W  = $clog2(ALPHABET);
    localparam int ROW_W  = ALPHABET * NODE_W + 1;
    localparam int MARK   = ROW_W - 1;

    logic [ROW_W-1:0] mem [MAX_NODES];

    item_t               item_reg;
    logic [NODE_W-1:0]   cursor_reg,       cursor_next;
    logic [CNT_W-1:0]    node_count_reg,   node_count_next;
    logic                path_missing_reg, path_missing_next;
    logic [STATUS_W-1:0] status_reg,       status_next;
    logic                root_written_reg, root_written_next;
    logic [ROW_W-1:0]    rd_row_reg;
    logic                rd_fresh_reg;
    result_t             result_reg,       result_next;
    logic                result_valid_reg, result_valid_next;

    logic [LETTER_W-1:0] in_diff;
    logic                in_ok;
    logic [LETTER_W-1:0] item_diff;
    logic [IDX_W-1:0]    idx;
    logic [ROW_W-1:0]    eff_row;
    logic [NODE_W-1:0]   child;
    logic                full;
    logic                we;
    logic [NODE_W-1:0]   wr_addr;
    logic [ROW_W-1:0]    wr_data;
    logic                is_lookup;

    assign in_diff   = item.letter - FIRST_LETTER;
    assign in_ok     = (item.letter >= FIRST_LETTER) && (in_diff < LETTER_W'(ALPHABET));
    assign item_diff = item_reg.letter - FIRST_LETTER;
    assign idx       = item_diff[IDX_W-1:0];
    assign eff_row   = rd_fresh_reg ? '0 : rd_row_reg;
    assign child     = eff_row[idx*NODE_W +: NODE_W];
    assign full      = node_count_reg >= CNT_W'(MAX_NODES);
    assign is_lookup = (item_reg.cmd == CMD_LOOKUP);

    assign stat.in_go     = !item.no_char && !path_missing_reg && in_ok;
    assign stat.in_last   = item.last;
    assign stat.item_last = item_reg.last;
    assign stat.alloc     = (child == '0) && !is_lookup && !full;
    assign stat.out_free  = !result_valid_reg || result_ready;

    always_comb
    begin
        cursor_next       = cursor_reg;
        node_count_next   = node_count_reg;
        path_missing_next = path_missing_reg;
        status_next       = status_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        we                = 1'b0;
        wr_addr           = cursor_reg;
        wr_data           = eff_row;

        if (cmd.accept && !item.no_char && !path_missing_reg && !in_ok)
        begin
            path_missing_next = 1'b1;
            if (status_reg == STAT_OK)
                status_next = STAT_BAD;
        end

        if (cmd.eval)
        begin
            if (child != '0)
            begin
                cursor_next = child;
            end
            else if (is_lookup)
            begin
                path_missing_next = 1'b1;
            end
            else if (full)
            begin
                path_missing_next = 1'b1;
                if (status_reg == STAT_OK)
                    status_next = STAT_FULL;
            end
            else
            begin
                we                            = 1'b1;
                wr_data[idx*NODE_W +: NODE_W] = node_count_reg[NODE_W-1:0];
                cursor_next                   = node_count_reg[NODE_W-1:0];
                node_count_next               = node_count_reg + 1'b1;
            end
        end

        if (cmd.zero)
        begin
            we      = 1'b1;
            wr_data = '0;
        end

        if (cmd.finish)
        begin
            if (!is_lookup && !path_missing_reg)
            begin
                we            = 1'b1;
                wr_data[MARK] = 1'b1;
            end
            result_next.word_found   = is_lookup && !path_missing_reg && eff_row[MARK];
            result_next.prefix_found = is_lookup && !path_missing_reg;
            result_next.status       = status_reg;
            result_next.nodes_used   = NODES_W'(node_count_reg);
            result_valid_next        = 1'b1;
            cursor_next              = '0;
            path_missing_next        = 1'b0;
            status_next              = STAT_OK;
        end
    end

    assign root_written_next = root_written_reg || (we && (wr_addr == '0));

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        rd_row_reg <= mem[cursor_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            item_reg <= item;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg       <= '0;
            node_count_reg   <= CNT_W'(1);
            path_missing_reg <= 1'b0;
            status_reg       <= STAT_OK;
            root_written_reg <= 1'b0;
            rd_fresh_reg     <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg       <= cursor_next;
            node_count_reg   <= node_count_next;
            path_missing_reg <= path_missing_next;
            status_reg       <= status_next;
            root_written_reg <= root_written_next;
            rd_fresh_reg     <= (cursor_reg == '0) && !root_written_reg;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[verif/trie_insert_lookup_unit_tb.sv]
// Self-checking testbench for trie_insert_lookup_unit: a shadow trie predicts every word result.
module trie_insert_lookup_unit_tb;
    import til_pkg::*;

    localparam int POOL_NODES = 256;
    localparam int ALPHA      = 26;
    localparam int MAX_LEN    = 6;
    localparam int DICT_N     = 64;
    localparam int WORD_ITEMS = 1850;
    localparam int CALM_AFTER = 1550;
    localparam int HOLD_AT    = 900;

    class trie_shadow;
        int unsigned         child_link [POOL_NODES*ALPHA];
        bit                  end_mark [POOL_NODES];
        int unsigned         cursor;
        int unsigned         node_total;
        bit                  path_broken;
        logic [STATUS_W-1:0] word_code;
        result_t             due_results [$];
        int                  mismatches;

        function new();
            foreach (child_link[i]) child_link[i] = 0;
            foreach (end_mark[i]) end_mark[i] = 1'b0;
            cursor      = 0;
            node_total  = 1;
            path_broken = 1'b0;
            word_code   = STAT_OK;
            mismatches  = 0;
        endfunction

        function void flag(logic [STATUS_W-1:0] code);
            if (word_code == STAT_OK)
                word_code = code;
        endfunction

        function void follow_letter(logic op, logic [LETTER_W-1:0] ch);
            int unsigned slot;
            int unsigned nxt;
            if (path_broken)
                return;
            if (ch < FIRST_LETTER || int'(ch) - int'(FIRST_LETTER) >= ALPHA)
            begin
                flag(STAT_BAD);
                path_broken = 1'b1;
                return;
            end
            slot = cursor * ALPHA + (int'(ch) - int'(FIRST_LETTER));
            nxt  = child_link[slot];
            if (nxt == 0)
            begin
                if (op == CMD_LOOKUP)
                begin
                    path_broken = 1'b1;
                    return;
                end
                if (node_total >= POOL_NODES)
                begin
                    flag(STAT_FULL);
                    path_broken = 1'b1;
                    return;
                end
                nxt = node_total;
                child_link[slot] = nxt;
                node_total++;
            end
            cursor = nxt;
        endfunction

        function void absorb_item(item_t it);
            result_t r;
            if (!it.no_char)
                follow_letter(it.cmd, it.letter);
            if (!it.last)
                return;
            r = '0;
            if (it.cmd == CMD_LOOKUP)
            begin
                if (!path_broken)
                begin
                    r.prefix_found = 1'b1;
                    r.word_found   = end_mark[cursor];
                end
            end
            else if (!path_broken)
                end_mark[cursor] = 1'b1;
            r.status     = word_code;
            r.nodes_used = NODES_W'(node_total);
            due_results.push_back(r);
            cursor      = 0;
            path_broken = 1'b0;
            word_code   = STAT_OK;
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                $error("result transaction with none pending: %h", got);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (got.word_found !== want.word_found)
            begin
                $error("word_found: expected %0d, got %0d", want.word_found, got.word_found);
                mismatches++;
            end
            if (got.prefix_found !== want.prefix_found)
            begin
                $error("prefix_found: expected %0d, got %0d",
                       want.prefix_found, got.prefix_found);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.nodes_used !== want.nodes_used)
            begin
                $error("nodes_used: expected %0d, got %0d", want.nodes_used, got.nodes_used);
                mismatches++;
            end
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    trie_shadow shadow;
    bit         idle_on = 1'b1;
    int         sent_items = 0;
    int         stall_left = 0;
    logic [LETTER_W-1:0] dict_text [DICT_N][MAX_LEN];
    int         dict_len [DICT_N];
    int         dict_fill = 0;
    int         dict_next = 0;

    trie_insert_lookup_unit #(
        .MAX_NODES(POOL_NODES),
        .ALPHABET (ALPHA)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ready = 1'b0;
            stall_left--;
        end
        else
        begin
            result_ready = 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 7);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            shadow.match_result(result);
    end

    function automatic item_t pack_item(logic op, logic [LETTER_W-1:0] ch, logic nc, logic ls);
        item_t it;
        it.cmd     = op;
        it.letter  = ch;
        it.no_char = nc;
        it.last    = ls;
        return it;
    endfunction

    task automatic send_item(item_t it);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_valid = 1'b0;
            item = item_t'(11'($urandom_range(0, 2047)));
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        item_valid = 1'b1;
        item = it;
        do
            @(posedge clk);
        while (!item_ready);
        shadow.absorb_item(it);
        sent_items++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid = 1'b0;
        while (shadow.due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_word();
        logic [LETTER_W-1:0] txt [MAX_LEN];
        int   len;
        int   pick;
        int   k;
        int   i;
        logic wcmd;
        bit   mixed;
        bit   clean;
        bit   wide;
        bit   tail;
        pick  = $urandom_range(0, 99);
        wcmd  = 1'($urandom_range(0, 1));
        mixed = ($urandom_range(0, 9) == 0);
        clean = 1'b1;
        len   = 0;
        if (pick < 45 && dict_fill > 0)
        begin
            k   = $urandom_range(0, dict_fill - 1);
            len = dict_len[k];
            for (i = 0; i < len; i++)
                txt[i] = dict_text[k][i];
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(1, len);
            else if ($urandom_range(0, 3) == 0 && len < MAX_LEN)
            begin
                txt[len] = FIRST_LETTER + LETTER_W'($urandom_range(0, 3));
                len++;
            end
        end
        else if (pick < 88)
        begin
            len  = $urandom_range(1, MAX_LEN);
            wide = ($urandom_range(0, 4) == 0);
            for (i = 0; i < len; i++)
                txt[i] = FIRST_LETTER
                         + LETTER_W'(wide ? $urandom_range(0, ALPHA - 1) : $urandom_range(0, 3));
        end
        else if (pick >= 94)
        begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++)
                txt[i] = LETTER_W'($urandom_range(0, 255));
            clean = 1'b0;
        end
        if (len > 0 && $urandom_range(0, 14) == 0)
        begin
            txt[$urandom_range(0, len - 1)] = LETTER_W'($urandom_range(0, 255));
            clean = 1'b0;
        end
        tail = (len > 0 && $urandom_range(0, 15) == 0);
        if (len == 0)
            send_item(pack_item(wcmd, LETTER_W'($urandom_range(0, 255)), 1'b1, 1'b1));
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(pack_item(mixed ? 1'($urandom_range(0, 1)) : wcmd,
                                    LETTER_W'($urandom_range(0, 255)), 1'b1, 1'b0));
            send_item(pack_item(mixed ? 1'($urandom_range(0, 1)) : wcmd, txt[i], 1'b0,
                                (i == len - 1) && !tail));
        end
        if (tail)
            send_item(pack_item(wcmd, LETTER_W'($urandom_range(0, 255)), 1'b1, 1'b1));
        if (wcmd == CMD_INSERT && !mixed && clean && len > 0)
        begin
            for (i = 0; i < len; i++)
                dict_text[dict_next][i] = txt[i];
            dict_len[dict_next] = len;
            dict_next = (dict_next + 1) % DICT_N;
            if (dict_fill < DICT_N)
                dict_fill++;
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("FAIL trie_insert_lookup_unit");
        $finish;
    end

    initial
    begin
        bit held;
        held   = 1'b0;
        shadow = new();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        send_item(pack_item(CMD_LOOKUP, 8'h00, 1'b1, 1'b1));
        send_item(pack_item(CMD_INSERT, 8'hFF, 1'b1, 1'b1));
        send_item(pack_item(CMD_LOOKUP, 8'h5A, 1'b1, 1'b1));
        send_item(pack_item(CMD_INSERT, "a", 1'b0, 1'b0));
        send_item(pack_item(CMD_INSERT, "z", 1'b0, 1'b1));
        send_item(pack_item(CMD_LOOKUP, "a", 1'b0, 1'b0));
        send_item(pack_item(CMD_LOOKUP, "z", 1'b0, 1'b1));
        send_item(pack_item(CMD_LOOKUP, "a", 1'b0, 1'b1));
        send_item(pack_item(CMD_LOOKUP, 8'hFF, 1'b0, 1'b1));
        send_item(pack_item(CMD_INSERT, 8'h00, 1'b0, 1'b0));
        send_item(pack_item(CMD_INSERT, "b", 1'b0, 1'b1));
        send_item(pack_item(CMD_INSERT, "c", 1'b0, 1'b0));
        send_item(pack_item(CMD_INSERT, "q", 1'b1, 1'b0));
        send_item(pack_item(CMD_INSERT, "d", 1'b0, 1'b1));
        send_item(pack_item(CMD_LOOKUP, "x", 1'b0, 1'b0));
        send_item(pack_item(CMD_INSERT, "y", 1'b0, 1'b1));
        send_item(pack_item(CMD_INSERT, 8'h60, 1'b0, 1'b1));
        send_item(pack_item(CMD_LOOKUP, 8'h7B, 1'b0, 1'b1));
        send_item(pack_item(CMD_LOOKUP, "c", 1'b0, 1'b0));
        send_item(pack_item(CMD_LOOKUP, "d", 1'b0, 1'b1));
        send_item(pack_item(CMD_INSERT, "z", 1'b0, 1'b0));
        send_item(pack_item(CMD_LOOKUP, "z", 1'b0, 1'b1));
        wait_drained();

        while (sent_items < WORD_ITEMS)
        begin
            if (sent_items >= CALM_AFTER)
                idle_on = 1'b0;
            if (!held && sent_items >= HOLD_AT)
            begin
                wait_drained();
                held = 1'b1;
            end
            random_word();
        end
        wait_drained();
        repeat (20) @(posedge clk);

        if (shadow.mismatches == 0 && shadow.due_results.size() == 0)
            $display("PASS trie_insert_lookup_unit");
        else
            $display("FAIL trie_insert_lookup_unit");
        $finish;
    end
endmodule
